@@ sv/iraf_pkg.sv @@
// Shared types, codes and character constants for the integer radix ASCII formatter.
package iraf_pkg;

  // Default configuration of the top level
  localparam int VALUE_BITS_DEF = 32;
  localparam int PAD_LIMIT_DEF  = 24;

  // Bit positions within format_flags
  localparam int F_SIGN  = 0;
  localparam int F_LEFT  = 1;
  localparam int F_ALT   = 2;
  localparam int F_ZERO  = 3;
  localparam int F_UPPER = 4;
  localparam int F_OCT   = 5;
  localparam int F_HEX   = 6;

  // Radix codes handed to the conversion unit
  localparam logic [1:0] RADIX_DEC = 2'd0;
  localparam logic [1:0] RADIX_OCT = 2'd1;
  localparam logic [1:0] RADIX_HEX = 2'd2;

  // ASCII characters
  localparam logic [7:0] ASCII_SPACE = 8'h20;
  localparam logic [7:0] ASCII_PLUS  = 8'h2B;
  localparam logic [7:0] ASCII_MINUS = 8'h2D;
  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_UC_A  = 8'h41;
  localparam logic [7:0] ASCII_LC_A  = 8'h61;
  localparam logic [7:0] ASCII_UC_X  = 8'h58;
  localparam logic [7:0] ASCII_LC_X  = 8'h78;

  // Per-item field description: alignment, case, sign/prefix text, width
  typedef struct packed {
    logic            left;
    logic            zpad;
    logic            upper;
    logic [1:0]      hlen;
    logic [2:0][7:0] chars;
    logic [7:0]      width;
  } iraf_head_t;

  // One digit value (0..15) to its ASCII character
  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] base;
    base = upper ? ASCII_UC_A : ASCII_LC_A;
    if (d < 4'd10) begin
      digit_char = ASCII_ZERO + {4'b0, d};
    end else begin
      digit_char = base + {4'b0, d} - 8'd10;
    end
  endfunction

endpackage

@@ sv/integer_radix_ascii_formatter.sv @@
// Top level of the integer radix ASCII formatter: input decode, conversion and emit.
//
// Formats one integer per item as a printf-style field and streams it out one ASCII
// character per output item, with last_char_o on the final one. An item is taken only
// while the block is idle. Decimal items pass through the shift-and-add-3 converter;
// octal and hex load their digits directly. A normalize pass then strips leading
// zeros one digit per cycle, and the emit sequencer sends one character per cycle
// while the output is not stalled, with a hand-over step between field segments. No
// clearing pass follows reset.
module integer_radix_ascii_formatter import iraf_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int PAD_LIMIT  = PAD_LIMIT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] value_i,
  input  logic        signed_type_i,
  input  logic [6:0]  format_flags_i,
  input  logic [7:0]  pad_width_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_char_o,
  output logic        last_char_o
);

  localparam int NDIG = (VALUE_BITS + 2) / 3;
  localparam int DW   = $clog2(NDIG + 1);

  logic [VALUE_BITS+31:0] vx;
  logic [VALUE_BITS-1:0]  v;
  logic [VALUE_BITS-1:0]  mag;
  logic                   neg;
  logic [1:0]             radix;
  logic                   acc;
  iraf_head_t             head_d, head_q;
  logic [1:0]             n;

  logic                   conv_busy;
  logic                   conv_done;
  logic [4*NDIG-1:0]      conv_digits;
  logic [DW-1:0]          conv_dlen;
  logic                   emit_busy;

  assign in_ready_o = !conv_busy && !emit_busy;
  assign acc        = in_valid_i && in_ready_o;

  // Operand: low VALUE_BITS, magnitude of a negative signed value
  always_comb begin
    vx    = {{VALUE_BITS{1'b0}}, value_i};
    v     = vx[VALUE_BITS-1:0];
    neg   = signed_type_i && v[VALUE_BITS-1];
    mag   = neg ? (~v + 1'b1) : v;
    if (format_flags_i[F_OCT]) begin
      radix = RADIX_OCT;
    end else if (format_flags_i[F_HEX]) begin
      radix = RADIX_HEX;
    end else begin
      radix = RADIX_DEC;
    end
  end

  // Sign and radix prefix text; zero prints with neither
  always_comb begin
    head_d.left  = format_flags_i[F_LEFT];
    head_d.zpad  = format_flags_i[F_ZERO];
    head_d.upper = format_flags_i[F_UPPER];
    head_d.width = pad_width_i;
    head_d.chars = '0;
    n            = 2'd0;
    if (mag != '0) begin
      if (neg) begin
        head_d.chars[0] = ASCII_MINUS;
        n               = 2'd1;
      end else if (format_flags_i[F_SIGN]) begin
        head_d.chars[0] = ASCII_PLUS;
        n               = 2'd1;
      end
      if (format_flags_i[F_ALT] && radix != RADIX_DEC) begin
        head_d.chars[n] = ASCII_ZERO;
        n               = n + 2'd1;
        if (radix == RADIX_HEX) begin
          head_d.chars[n] = format_flags_i[F_UPPER] ? ASCII_UC_X : ASCII_LC_X;
          n               = n + 2'd1;
        end
      end
    end
    head_d.hlen = n;
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      head_q <= head_d;
    end
  end

  iraf_conv #(
    .VALUE_BITS (VALUE_BITS)
  ) u_conv (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (acc),
    .mag_i    (mag),
    .radix_i  (radix),
    .busy_o   (conv_busy),
    .done_o   (conv_done),
    .digits_o (conv_digits),
    .dlen_o   (conv_dlen)
  );

  iraf_emit #(
    .VALUE_BITS (VALUE_BITS),
    .PAD_LIMIT  (PAD_LIMIT)
  ) u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (conv_done),
    .head_i      (head_q),
    .digits_i    (conv_digits),
    .dlen_i      (conv_dlen),
    .busy_o      (emit_busy),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_char_o  (out_char_o),
    .last_char_o (last_char_o)
  );

  // Conversion hands over only to an idle sequencer
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    conv_done |-> !emit_busy)
    else $error("conversion finished while emit sequencer busy");

  // An accepted item holds off the next one
  a_busy_after_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> !in_ready_o)
    else $error("ready right after accepting an item");

  // Digit count handed over is at least one and within the digit store
  a_dlen_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    conv_done |-> (conv_dlen != '0) && (conv_dlen <= DW'(NDIG)))
    else $error("digit count out of range");

endmodule

@@ sv/iraf_conv.sv @@
// Digit conversion unit: shift-and-add-3 for decimal, direct split for octal/hex,
// then a leading-zero normalize pass one digit per cycle.
module iraf_conv import iraf_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [VALUE_BITS-1:0]             mag_i,
  input  logic [1:0]                        radix_i,
  output logic                              busy_o,
  output logic                              done_o,
  output logic [4*((VALUE_BITS+2)/3)-1:0]   digits_o,
  output logic [$clog2((VALUE_BITS+2)/3+1)-1:0] dlen_o
);

  localparam int NDIG = (VALUE_BITS + 2) / 3;
  localparam int DW   = $clog2(NDIG + 1);
  localparam int BW   = $clog2(VALUE_BITS + 1);
  localparam int XW   = VALUE_BITS + 4 * NDIG;

  localparam logic [1:0] C_IDLE = 2'd0;
  localparam logic [1:0] C_DAB  = 2'd1;
  localparam logic [1:0] C_NORM = 2'd2;

  logic [1:0]            state_q, state_d;
  logic [4*NDIG-1:0]     bcd_q, bcd_d;
  logic [VALUE_BITS-1:0] sh_q, sh_d;
  logic [BW-1:0]         bit_q, bit_d;
  logic [DW-1:0]         dlen_q, dlen_d;

  logic [XW-1:0]         ext;
  logic [4*NDIG-1:0]     oct_ld;
  logic [4*NDIG-1:0]     hex_ld;
  logic [4*NDIG-1:0]     adj;
  logic                  done;

  // Direct digit split for power-of-two radixes
  always_comb begin
    ext    = {{(4*NDIG){1'b0}}, mag_i};
    hex_ld = ext[4*NDIG-1:0];
    for (int i = 0; i < NDIG; i++) begin
      oct_ld[4*i +: 4] = {1'b0, ext[3*i +: 3]};
    end
  end

  // Add-3 correction on every BCD digit that is five or more
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    bcd_d   = bcd_q;
    sh_d    = sh_q;
    bit_d   = bit_q;
    dlen_d  = dlen_q;
    done    = 1'b0;
    case (state_q)
      C_IDLE: begin
        if (start_i) begin
          dlen_d = DW'(NDIG);
          if (radix_i == RADIX_DEC) begin
            bcd_d   = '0;
            sh_d    = mag_i;
            bit_d   = BW'(VALUE_BITS);
            state_d = C_DAB;
          end else begin
            bcd_d   = (radix_i == RADIX_OCT) ? oct_ld : hex_ld;
            state_d = C_NORM;
          end
        end
      end
      C_DAB: begin
        bcd_d = {adj[4*NDIG-2:0], sh_q[VALUE_BITS-1]};
        sh_d  = sh_q << 1;
        bit_d = bit_q - 1'b1;
        if (bit_q == BW'(1)) begin
          state_d = C_NORM;
        end
      end
      C_NORM: begin
        // strip leading zeros, keeping at least one digit
        if (bcd_q[4*NDIG-1 -: 4] == 4'd0 && dlen_q > DW'(1)) begin
          bcd_d  = bcd_q << 4;
          dlen_d = dlen_q - 1'b1;
        end else begin
          done    = 1'b1;
          state_d = C_IDLE;
        end
      end
      default: begin
        state_d = C_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bcd_q  <= bcd_d;
    sh_q   <= sh_d;
    bit_q  <= bit_d;
    dlen_q <= dlen_d;
  end

  assign busy_o   = (state_q != C_IDLE);
  assign done_o   = done;
  assign digits_o = bcd_q;
  assign dlen_o   = dlen_q;

endmodule

@@ sv/iraf_emit.sv @@
// Character sequencer: padding, sign/prefix and digits into a registered output stage.
module iraf_emit import iraf_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int PAD_LIMIT  = PAD_LIMIT_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  iraf_head_t                            head_i,
  input  logic [4*((VALUE_BITS+2)/3)-1:0]       digits_i,
  input  logic [$clog2((VALUE_BITS+2)/3+1)-1:0] dlen_i,
  output logic                                  busy_o,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [7:0]                            out_char_o,
  output logic                                  last_char_o
);

  localparam int NDIG = (VALUE_BITS + 2) / 3;
  localparam int DW   = $clog2(NDIG + 1);
  localparam int PW   = $clog2(PAD_LIMIT + 1);
  localparam int RW   = $clog2(3 + NDIG + PAD_LIMIT + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PRE  = 3'd1;
  localparam logic [2:0] S_HEAD = 3'd2;
  localparam logic [2:0] S_ZERO = 3'd3;
  localparam logic [2:0] S_DIG  = 3'd4;
  localparam logic [2:0] S_POST = 3'd5;

  logic [2:0]        seg_q, seg_d;
  iraf_head_t        head_q, head_d;
  logic [4*NDIG-1:0] dsr_q, dsr_d;
  logic [DW-1:0]     dc_q, dc_d;
  logic [1:0]        hc_q, hc_d;
  logic [PW-1:0]     pc_q, pc_d;
  logic [RW-1:0]     rem_q, rem_d;
  logic              ov_q, ov_d;
  logic [7:0]        oc_q, oc_d;
  logic              ol_q, ol_d;

  logic [7:0]        total;
  logic [7:0]        diff;
  logic [PW-1:0]     pad;
  logic              take;
  logic              emit;
  logic [7:0]        ch;

  // Pad amount: width minus text length, floored at zero, capped
  always_comb begin
    total = 8'(head_i.hlen) + 8'(dlen_i);
    diff  = (head_i.width > total) ? (head_i.width - total) : 8'd0;
    pad   = (diff > 8'(PAD_LIMIT)) ? PW'(PAD_LIMIT) : diff[PW-1:0];
  end

  always_comb begin
    seg_d  = seg_q;
    head_d = head_q;
    dsr_d  = dsr_q;
    dc_d   = dc_q;
    hc_d   = hc_q;
    pc_d   = pc_q;
    rem_d  = rem_q;
    ov_d   = ov_q;
    oc_d   = oc_q;
    ol_d   = ol_q;
    emit   = 1'b0;
    ch     = ASCII_SPACE;
    take   = !ov_q || out_ready_i;

    if (start_i) begin
      head_d = head_i;
      dsr_d  = digits_i;
      dc_d   = dlen_i;
      hc_d   = 2'd0;
      pc_d   = pad;
      rem_d  = RW'(total) + RW'(pad);
      seg_d  = (!head_i.left && !head_i.zpad) ? S_PRE : S_HEAD;
    end else if (take) begin
      case (seg_q)
        S_IDLE: begin
        end
        S_PRE: begin
          if (pc_q != '0) begin
            emit = 1'b1;
            ch   = ASCII_SPACE;
            pc_d = pc_q - 1'b1;
          end else begin
            seg_d = S_HEAD;
          end
        end
        S_HEAD: begin
          if (hc_q != head_q.hlen) begin
            emit = 1'b1;
            ch   = head_q.chars[hc_q];
            hc_d = hc_q + 2'd1;
          end else begin
            seg_d = (head_q.zpad && !head_q.left) ? S_ZERO : S_DIG;
          end
        end
        S_ZERO: begin
          if (pc_q != '0) begin
            emit = 1'b1;
            ch   = ASCII_ZERO;
            pc_d = pc_q - 1'b1;
          end else begin
            seg_d = S_DIG;
          end
        end
        S_DIG: begin
          if (dc_q != '0) begin
            emit  = 1'b1;
            ch    = digit_char(dsr_q[4*NDIG-1 -: 4], head_q.upper);
            dsr_d = dsr_q << 4;
            dc_d  = dc_q - 1'b1;
          end else begin
            seg_d = S_POST;
          end
        end
        S_POST: begin
          if (pc_q != '0) begin
            emit = 1'b1;
            ch   = ASCII_SPACE;
            pc_d = pc_q - 1'b1;
          end else begin
            seg_d = S_IDLE;
          end
        end
        default: begin
          seg_d = S_IDLE;
        end
      endcase
    end

    // Output register: load on emit, drop once taken
    if (emit) begin
      oc_d  = ch;
      ol_d  = (rem_q == RW'(1));
      ov_d  = 1'b1;
      rem_d = rem_q - 1'b1;
      if (rem_q == RW'(1)) begin
        seg_d = S_IDLE;
      end
    end else if (out_ready_i) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q <= S_IDLE;
      ov_q  <= 1'b0;
    end else begin
      seg_q <= seg_d;
      ov_q  <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    dsr_q  <= dsr_d;
    dc_q   <= dc_d;
    hc_q   <= hc_d;
    pc_q   <= pc_d;
    rem_q  <= rem_d;
    oc_q   <= oc_d;
    ol_q   <= ol_d;
  end

  assign busy_o      = (seg_q != S_IDLE);
  assign out_valid_o = ov_q;
  assign out_char_o  = oc_q;
  assign last_char_o = ol_q;

endmodule

@@ test/tb_integer_radix_ascii_formatter.sv @@
// Self-checking testbench for the integer radix ASCII formatter.
`timescale 1ns / 100ps

module tb_integer_radix_ascii_formatter import iraf_pkg::*;;

  localparam int VBITS      = VALUE_BITS_DEF;
  localparam int PAD_CAP    = PAD_LIMIT_DEF;
  localparam int RAND_ITEMS = 400;
  localparam int IDLE_LIMIT = 4000;
  localparam int TAIL_WAIT  = 100;

  // Flag masks built from the package bit positions
  localparam logic [6:0] FL_SIGN  = 7'b1 << F_SIGN;
  localparam logic [6:0] FL_LEFT  = 7'b1 << F_LEFT;
  localparam logic [6:0] FL_ALT   = 7'b1 << F_ALT;
  localparam logic [6:0] FL_ZERO  = 7'b1 << F_ZERO;
  localparam logic [6:0] FL_UPPER = 7'b1 << F_UPPER;
  localparam logic [6:0] FL_OCT   = 7'b1 << F_OCT;
  localparam logic [6:0] FL_HEX   = 7'b1 << F_HEX;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } field_char_t;

  typedef struct {
    logic [31:0] value;
    logic        sgn;
    logic [6:0]  flags;
    logic [7:0]  width;
    string       want;   // empty: use the predictor
  } dir_row_t;

  typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_SPARSE, RX_BLOCKED} rx_mode_t;

  logic        clk_i;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        in_ready_o;
  logic [31:0] value_i        = '0;
  logic        signed_type_i  = 1'b0;
  logic [6:0]  format_flags_i = '0;
  logic [7:0]  pad_width_i    = '0;
  logic        out_valid_o;
  logic        out_ready_i    = 1'b0;
  logic [7:0]  out_char_o;
  logic        last_char_o;

  field_char_t pending_chars[$];
  int          err_count  = 0;
  int          idle_count = 0;
  int          burst_left = 0;
  rx_mode_t    rx_mode    = RX_FREE;
  int          rx_hold    = 0;

  integer_radix_ascii_formatter DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .value_i        (value_i),
    .signed_type_i  (signed_type_i),
    .format_flags_i (format_flags_i),
    .pad_width_i    (pad_width_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_char_o     (out_char_o),
    .last_char_o    (last_char_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    err_count++;
  endtask

  // Predict the formatted field and queue its characters
  function automatic void format_field(input logic [31:0] value, input logic is_signed,
                                       input logic [6:0] flags, input logic [7:0] width);
    logic [63:0] mask;
    logic [63:0] mag;
    logic        neg;
    int          radix;
    int          total;
    int          pad;
    string       dg;
    logic [7:0]  head[$];
    logic [7:0]  digs[$];
    logic [7:0]  text_q[$];
    mask  = ((64'd1 << (VBITS - 1)) << 1) - 64'd1;
    mag   = {32'b0, value} & mask;
    neg   = 1'b0;
    dg    = flags[F_UPPER] ? "0123456789ABCDEF" : "0123456789abcdef";
    radix = flags[F_OCT] ? 8 : (flags[F_HEX] ? 16 : 10);

    // Two's complement magnitude; the most negative value maps onto itself
    if (is_signed && mag[VBITS-1]) begin
      neg = 1'b1;
      mag = (~mag + 64'd1) & mask;
    end

    if (mag == 0) begin
      digs.push_back(ASCII_ZERO);
    end else begin
      if (neg) begin
        head.push_back(ASCII_MINUS);
      end else if (flags[F_SIGN]) begin
        head.push_back(ASCII_PLUS);
      end
      if (flags[F_ALT] && (flags[F_OCT] || flags[F_HEX])) begin
        head.push_back(ASCII_ZERO);
        if (!flags[F_OCT]) begin
          head.push_back(flags[F_UPPER] ? ASCII_UC_X : ASCII_LC_X);
        end
      end
      while (mag != 0) begin
        digs.push_front(dg[int'(mag % radix)]);
        mag = mag / radix;
      end
    end

    total = head.size() + digs.size();
    pad   = (int'(width) > total) ? int'(width) - total : 0;
    if (pad > PAD_CAP) pad = PAD_CAP;

    // Assemble by alignment mode
    if (flags[F_LEFT]) begin
      text_q = {head, digs};
      repeat (pad) text_q.push_back(ASCII_SPACE);
    end else if (flags[F_ZERO]) begin
      text_q = head;
      repeat (pad) text_q.push_back(ASCII_ZERO);
      text_q = {text_q, digs};
    end else begin
      repeat (pad) text_q.push_back(ASCII_SPACE);
      text_q = {text_q, head, digs};
    end

    foreach (text_q[i]) begin
      pending_chars.push_back('{ch: text_q[i], last: (i == text_q.size() - 1)});
    end
  endfunction

  // Queue a field whose text is known by hand
  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      pending_chars.push_back('{ch: s[i], last: (i == s.len() - 1)});
    end
  endtask

  // Sender pacing: bursts of random length, random gaps between them
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 9);
      case ($urandom_range(0, 5))
        0:       gap = 0;
        1:       gap = $urandom_range(40, 120);
        default: gap = $urandom_range(1, 12);
      endcase
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Present one item, wait for acceptance, then record what it should produce
  task automatic send_item(input logic [31:0] value, input logic sgn, input logic [6:0] flags,
                           input logic [7:0] width, input string want);
    in_valid_i     <= 1'b1;
    value_i        <= value;
    signed_type_i  <= sgn;
    format_flags_i <= flags;
    pad_width_i    <= width;
    do @(posedge clk_i); while (!in_ready_o);
    if (want.len() > 0) begin
      queue_text(want);
    end else begin
      format_field(value, sgn, flags, width);
    end
  endtask

  // Receiver stall pattern: a random mode, held for a random span before it changes
  always @(posedge clk_i) begin
    if (rx_hold == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_hold <= $urandom_range(20, 150);
    end else begin
      rx_hold <= rx_hold - 1;
    end
    case (rx_mode)
      RX_FREE:   out_ready_i <= 1'b1;
      RX_COIN:   out_ready_i <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_ready_i <= ($urandom_range(0, 5) == 0);
      default:   out_ready_i <= (rx_hold[3:0] == 4'd0);
    endcase
  end

  // Output checker
  always @(posedge clk_i) begin
    field_char_t exp_c;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected char 0x%02h last=%0b", out_char_o, last_char_o));
      end else begin
        exp_c = pending_chars.pop_front();
        if (out_char_o !== exp_c.ch) begin
          report_mismatch($sformatf("out_char 0x%02h, expected 0x%02h", out_char_o, exp_c.ch));
        end
        if (last_char_o !== exp_c.last) begin
          report_mismatch($sformatf("last_char %0b, expected %0b", last_char_o, exp_c.last));
        end
      end
    end
  end

  // Cycles without any accepted item on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_count <= 0;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  // Watchdog
  initial begin
    while (idle_count < IDLE_LIMIT) @(posedge clk_i);
    $display("Mismatches found");
    $finish;
  end

  // Main sequence
  initial begin
    dir_row_t    rows[$];
    logic [31:0] rv;
    logic [7:0]  rw;

    // Directed rows: extremes, radix and flag corner cases
    rows.push_back('{32'h0000_0000, 1'b0, 7'h00, 8'd0, "0"});
    rows.push_back('{32'h0000_0000, 1'b1, FL_SIGN | FL_ALT | FL_HEX, 8'd0, "0"});
    rows.push_back('{32'hFFFF_FFFF, 1'b0, 7'h00, 8'd0, "4294967295"});
    rows.push_back('{32'hFFFF_FFFF, 1'b1, 7'h00, 8'd0, "-1"});
    rows.push_back('{32'h8000_0000, 1'b1, 7'h00, 8'd0, "-2147483648"});
    rows.push_back('{32'h7FFF_FFFF, 1'b1, FL_SIGN, 8'd0, "+2147483647"});
    rows.push_back('{32'hFFFF_FFFF, 1'b0, FL_HEX | FL_UPPER | FL_ALT, 8'd0, "0XFFFFFFFF"});
    rows.push_back('{32'hDEAD_BEEF, 1'b0, FL_HEX | FL_ALT, 8'd0, "0xdeadbeef"});
    rows.push_back('{32'hFFFF_FFFF, 1'b0, FL_OCT | FL_ALT, 8'd0, "037777777777"});
    rows.push_back('{32'd8, 1'b0, FL_OCT | FL_HEX, 8'd0, "10"});
    rows.push_back('{32'd5, 1'b0, FL_ALT, 8'd0, "5"});
    rows.push_back('{32'hFFFF_FFFB, 1'b1, FL_SIGN, 8'd0, "-5"});
    rows.push_back('{32'hFFFF_FFF0, 1'b1, FL_HEX | FL_ALT, 8'd0, "-0x10"});
    rows.push_back('{32'd42, 1'b0, FL_ZERO, 8'd6, "000042"});
    rows.push_back('{32'd42, 1'b0, FL_ZERO | FL_SIGN, 8'd6, "+00042"});
    rows.push_back('{32'd42, 1'b0, FL_LEFT | FL_ZERO, 8'd5, "42   "});
    rows.push_back('{32'd7, 1'b0, 7'h00, 8'd3, "  7"});
    rows.push_back('{32'd123, 1'b0, 7'h00, 8'd3, "123"});
    rows.push_back('{32'd0, 1'b0, FL_ZERO, 8'd5, "00000"});
    rows.push_back('{32'd1, 1'b0, 7'h00, 8'd255, ""});
    rows.push_back('{32'd0, 1'b1, FL_ZERO, 8'd200, ""});
    rows.push_back('{32'hFFFF_FFF8, 1'b1, FL_OCT | FL_ZERO | FL_ALT, 8'd8, ""});
    rows.push_back('{32'h8000_0000, 1'b1, 7'h7F, 8'd255, ""});
    rows.push_back('{32'hABCD_0123, 1'b1, FL_HEX | FL_UPPER | FL_SIGN | FL_ZERO, 8'd14, ""});

    // Reset
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      pace_sender();
      send_item(rows[i].value, rows[i].sgn, rows[i].flags, rows[i].width, rows[i].want);
    end

    // Random items, weighted toward interesting values and small widths
    for (int n = 0; n < RAND_ITEMS; n++) begin
      case ($urandom_range(0, 9))
        0:       rv = 32'd0;
        1:       rv = 32'($urandom_range(1, 20));
        2: begin
          case ($urandom_range(0, 4))
            0:       rv = 32'h8000_0000;
            1:       rv = 32'hFFFF_FFFF;
            2:       rv = 32'h7FFF_FFFF;
            3:       rv = 32'h8000_0001;
            default: rv = 32'd1;
          endcase
        end
        3:       rv = 32'(-$urandom_range(1, 100));
        default: rv = 32'($urandom);
      endcase
      case ($urandom_range(0, 9))
        0:       rw = 8'($urandom_range(0, 255));
        1, 2:    rw = 8'($urandom_range(16, 40));
        default: rw = 8'($urandom_range(0, 15));
      endcase
      pace_sender();
      send_item(rv, 1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)), rw, "");
    end
    in_valid_i <= 1'b0;

    // Drain, then give the block time to show anything extra
    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (TAIL_WAIT) @(posedge clk_i);
    if (pending_chars.size() != 0) begin
      report_mismatch($sformatf("%0d expected chars never arrived", pending_chars.size()));
    end

    if (err_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
